FILE: rtl/nsa_pkg.sv
package nsa_pkg;

	localparam int STATES = 16;
	localparam int SYMBOLS = 16;
	localparam int ROWS = SYMBOLS + 1;
	localparam int ROW_AW = $clog2(ROWS);

	localparam int STATE_W = 4;
	localparam int SYM_W = 5;
	localparam int MASK_W = 16;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	typedef logic [STATES-1:0] state_set_t;
	typedef logic [ROW_AW-1:0] row_addr_t;

	localparam row_addr_t EPS_ROW = row_addr_t'(SYMBOLS);
	localparam row_addr_t LAST_ROW = row_addr_t'(ROWS - 1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SYMBOL = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_STATE = 1'd0,
		REG_FINAL_MASK = 1'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		SET_HOLD,
		SET_MOVE,
		SET_GROW,
		SET_START
	} set_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOVE,
		ST_CLOSE,
		ST_EMIT,
		ST_REARM
	} ctrl_state_t;

	typedef struct packed {
		logic clear;
		logic load_we;
		logic capture;
		logic rd_sym;
		set_op_t set_op;
		logic out_load;
	} nsa_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic closed;
		logic out_free;
		logic last;
	} nsa_sts_t;

	function automatic state_set_t nsa_move(input state_set_t set,
		input state_set_t [STATES-1:0] rows);
		state_set_t acc;
		acc = '0;
		for (int s = 0; s < STATES; s++) begin
			if (set[s]) begin
				acc = acc | rows[s];
			end
		end
		return acc;
	endfunction

endpackage

FILE: rtl/nsa_item_if.sv
interface nsa_item_if;
	import nsa_pkg::*;

	logic valid;
	logic ready;
	logic mode;
	logic [STATE_W-1:0] row_state;
	logic [SYM_W-1:0] symbol;
	logic [MASK_W-1:0] next_set;
	logic last_symbol;

	modport source(output valid, mode, row_state, symbol, next_set, last_symbol,
		input ready);
	modport sink(input valid, mode, row_state, symbol, next_set, last_symbol,
		output ready);
endinterface

FILE: rtl/nsa_result_if.sv
interface nsa_result_if;
	logic valid;
	logic ready;
	logic accepted;
	logic alive;
	logic string_done;

	modport source(output valid, accepted, alive, string_done, input ready);
	modport sink(input valid, accepted, alive, string_done, output ready);
endinterface

FILE: rtl/nsa_ram.sv
module nsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 17
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/nsa_cfg.sv
module nsa_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [nsa_pkg::PADDR_W-1:0] paddr,
	input logic [nsa_pkg::PDATA_W-1:0] pwdata,
	output logic [nsa_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	output logic [nsa_pkg::STATE_W-1:0] start_state,
	output logic [nsa_pkg::MASK_W-1:0] final_mask
);
	import nsa_pkg::*;

	logic [STATE_W-1:0] start_state_q;
	logic [MASK_W-1:0] final_mask_q;
	reg_idx_t idx;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign start_state = start_state_q;
	assign final_mask = final_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			final_mask_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_START_STATE: start_state_q <= pwdata[STATE_W-1:0];
				REG_FINAL_MASK: final_mask_q <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_START_STATE: prdata = PDATA_W'(start_state_q);
			REG_FINAL_MASK: prdata = PDATA_W'(final_mask_q);
			default: prdata = '0;
		endcase
	end
endmodule

FILE: rtl/nsa_ctrl.sv
module nsa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_mode,
	output logic item_ready,
	input nsa_pkg::nsa_sts_t sts,
	output nsa_pkg::nsa_cmd_t cmd
);
	import nsa_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		cmd = '0;
		cmd.set_op = SET_HOLD;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.rd_sym = 1'b1;
				if (item_valid) begin
					if (item_mode == MODE_SYMBOL) begin
						cmd.capture = 1'b1;
						state_d = ST_MOVE;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_MOVE: begin
				cmd.set_op = SET_MOVE;
				state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				if (sts.closed) begin
					state_d = ST_EMIT;
				end else begin
					cmd.set_op = SET_GROW;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last) begin
						cmd.set_op = SET_START;
						state_d = ST_REARM;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_REARM: begin
				if (sts.closed) begin
					state_d = ST_IDLE;
				end else begin
					cmd.set_op = SET_GROW;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end
endmodule

FILE: rtl/nsa_dp.sv
module nsa_dp (
	input logic clk,
	input logic arst_n,
	input nsa_pkg::nsa_cmd_t cmd,
	output nsa_pkg::nsa_sts_t sts,
	input logic [nsa_pkg::STATE_W-1:0] row_state,
	input logic [nsa_pkg::SYM_W-1:0] symbol,
	input logic [nsa_pkg::MASK_W-1:0] next_set,
	input logic last_symbol,
	input logic [nsa_pkg::STATE_W-1:0] start_state,
	input logic [nsa_pkg::MASK_W-1:0] final_mask,
	nsa_result_if.source result
);
	import nsa_pkg::*;

	state_set_t [STATES-1:0] rows_rd;
	state_set_t set_q;
	state_set_t moved;
	state_set_t grown;
	state_set_t start_set;
	state_set_t wdata;
	row_addr_t clr_q;
	row_addr_t wr_addr;
	row_addr_t rd_addr;
	logic row_ok;
	logic last_q;
	logic foreign_q;
	logic out_valid_q;
	logic accepted_q;
	logic alive_q;
	logic done_q;

	assign row_ok = (int'(row_state) < STATES) && (int'(symbol) <= SYMBOLS);
	assign wr_addr = cmd.clear ? clr_q : row_addr_t'(symbol);
	assign rd_addr = cmd.rd_sym ? row_addr_t'(symbol) : EPS_ROW;
	assign wdata = cmd.clear ? '0 : state_set_t'(next_set);

	for (genvar s = 0; s < STATES; s++) begin : g_lane
		logic we;
		assign we = cmd.clear ||
			(cmd.load_we && row_ok && (row_state == STATE_W'(s)));
		nsa_ram #(
			.WIDTH(STATES),
			.DEPTH(ROWS)
		) u_ram (
			.clk(clk),
			.we(we),
			.waddr(wr_addr),
			.wdata(wdata),
			.raddr(rd_addr),
			.rdata(rows_rd[s])
		);
	end

	assign moved = nsa_move(set_q, rows_rd);
	assign grown = set_q | moved;
	assign start_set = (int'(start_state) < STATES) ?
		(state_set_t'(1) << start_state) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= state_set_t'(1);
			clr_q <= '0;
			last_q <= 1'b0;
			foreign_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + row_addr_t'(1);
			end
			if (cmd.capture) begin
				last_q <= last_symbol;
				foreign_q <= int'(symbol) >= SYMBOLS;
			end
			case (cmd.set_op)
				SET_MOVE: set_q <= foreign_q ? '0 : moved;
				SET_GROW: set_q <= grown;
				SET_START: set_q <= start_set;
				default: ;
			endcase
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			accepted_q <= |(set_q & state_set_t'(final_mask));
			alive_q <= |set_q;
			done_q <= last_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.accepted = accepted_q;
	assign result.alive = alive_q;
	assign result.string_done = done_q;

	assign sts.clear_done = (clr_q == LAST_ROW);
	assign sts.closed = (grown == set_q);
	assign sts.out_free = !out_valid_q || result.ready;
	assign sts.last = last_q;
endmodule

FILE: rtl/nfa_string_acceptor_unit.sv
// Bit-parallel NFA acceptor. After reset the transition table is cleared in one pass,
// one row address per cycle, during which no item is taken. A load beat writes one
// transition row and leaves the block ready for the next beat. A symbol beat runs
// through the move, close and emit states before the next beat can be taken; the
// close state runs epsilon passes until the active set stops growing (0 to 15
// growing passes): each pass ORs the epsilon rows of all active states, read from
// one RAM per state. A beat that ends a string then passes the rearm state, which
// re-closes the start state with its own growing passes. A result still waiting in
// the output register holds the next result in the emit state, stalling the input too.
module nfa_string_acceptor_unit (
	input logic clk,
	input logic arst_n,
	nsa_item_if.sink item,
	nsa_result_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [nsa_pkg::PADDR_W-1:0] paddr,
	input logic [nsa_pkg::PDATA_W-1:0] pwdata,
	output logic [nsa_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	import nsa_pkg::*;

	nsa_cmd_t cmd;
	nsa_sts_t sts;
	logic [STATE_W-1:0] start_state;
	logic [MASK_W-1:0] final_mask;

	nsa_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start_state(start_state),
		.final_mask(final_mask)
	);

	nsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_mode(item.mode),
		.item_ready(item.ready),
		.sts(sts),
		.cmd(cmd)
	);

	nsa_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.row_state(item.row_state),
		.symbol(item.symbol),
		.next_set(item.next_set),
		.last_symbol(item.last_symbol),
		.start_state(start_state),
		.final_mask(final_mask),
		.result(result)
	);
endmodule

FILE: tb/sv/nfa_verdict_pkg.sv
package nfa_verdict_pkg;
	import nsa_pkg::*;

	typedef struct packed {
		logic accepted;
		logic alive;
		logic string_done;
	} verdict_t;

	class nfa_verdict_tracker;
		state_set_t trans[STATES][ROWS];
		state_set_t active;
		logic [STATE_W-1:0] start_idx;
		state_set_t final_set;
		verdict_t verdicts_due[$];
		int errors;
		int checked;
		int accepts;
		int alives;

		function new();
			foreach (trans[s, c]) begin
				trans[s][c] = '0;
			end
			start_idx = '0;
			final_set = '0;
			errors = 0;
			checked = 0;
			accepts = 0;
			alives = 0;
			active = start_closure();
		endfunction

		function state_set_t follow_symbol(state_set_t set, int sym);
			state_set_t next;
			next = '0;
			for (int s = 0; s < STATES; s++) begin
				if (set[s]) begin
					next |= trans[s][sym];
				end
			end
			return next;
		endfunction

		// Each pass adds the epsilon targets of the whole set; stop once nothing grows.
		function state_set_t epsilon_close(state_set_t set);
			state_set_t grown;
			for (int p = 0; p < STATES; p++) begin
				grown = set | follow_symbol(set, SYMBOLS);
				if (grown == set) begin
					break;
				end
				set = grown;
			end
			return set;
		endfunction

		function state_set_t start_closure();
			return epsilon_close(state_set_t'(1) << start_idx);
		endfunction

		function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_START_STATE: start_idx = value[STATE_W-1:0];
				REG_FINAL_MASK: final_set = value[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic mode, logic [STATE_W-1:0] row, logic [SYM_W-1:0] sym,
			logic [MASK_W-1:0] nset, logic last);
			verdict_t v;
			if (mode == MODE_LOAD) begin
				if (sym <= SYMBOLS) begin
					trans[row][sym] = nset;
				end
				return;
			end
			if (sym < SYMBOLS) begin
				active = epsilon_close(follow_symbol(active, int'(sym)));
			end else begin
				active = '0;
			end
			v.accepted = |(active & final_set);
			v.alive = |active;
			v.string_done = last;
			verdicts_due = {verdicts_due, v};
			if (last) begin
				active = start_closure();
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected verdict: expected none, actual acc=%0b alive=%0b done=%0b",
					$time, got.accepted, got.alive, got.string_done);
				return;
			end
			want = verdicts_due.pop_front();
			checked++;
			accepts += want.accepted;
			alives += want.alive;
			if (got.accepted !== want.accepted || got.alive !== want.alive
				|| got.string_done !== want.string_done) begin
				errors++;
				$display("%0t: verdict mismatch: expected acc=%0b alive=%0b done=%0b",
					$time, want.accepted, want.alive, want.string_done);
				$display("%0t:                   actual acc=%0b alive=%0b done=%0b",
					$time, got.accepted, got.alive, got.string_done);
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nsa_pkg::*;
	import nfa_verdict_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASES = 8;
	localparam int SYMBOLS_PER_PHASE = 160;

	typedef enum int {
		RX_OPEN,
		RX_EVERY_EIGHTH,
		RX_COIN,
		RX_LONG_STALL
	} rx_pattern_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	nsa_item_if item_bus();
	nsa_result_if verdict_bus();

	nfa_string_acceptor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(verdict_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	nfa_verdict_tracker tracker = new();
	int burst_left = 0;
	bit gaps_on = 1'b1;
	rx_pattern_t rx_mode = RX_OPEN;
	int rx_count = 0;
	int idle_cycles = 0;
	int loads = 0;
	int symbols = 0;
	int strings = 0;
	int settings = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rx_count <= rx_count + 1;
		if (arst_n && verdict_bus.valid && verdict_bus.ready) begin
			tracker.check_verdict(verdict_t'({verdict_bus.accepted, verdict_bus.alive,
				verdict_bus.string_done}));
		end
		if (!arst_n) begin
			verdict_bus.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: verdict_bus.ready <= 1'b1;
				RX_EVERY_EIGHTH: verdict_bus.ready <= (rx_count % 8) != 0;
				RX_COIN: verdict_bus.ready <= 1'($urandom_range(0, 1));
				default: verdict_bus.ready <= (rx_count % 29) >= 17;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_bus.valid && item_bus.ready)
			|| (verdict_bus.valid && verdict_bus.ready) || psel) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [MASK_W-1:0] sparse_set(int odds);
		logic [MASK_W-1:0] set;
		set = '0;
		if ($urandom_range(0, odds) != 0) begin
			set[$urandom_range(0, MASK_W - 1)] = 1'b1;
		end
		if ($urandom_range(0, 2) == 0) begin
			set[$urandom_range(0, MASK_W - 1)] = 1'b1;
		end
		return set;
	endfunction

	task automatic send_item(logic mode, logic [STATE_W-1:0] row, logic [SYM_W-1:0] sym,
		logic [MASK_W-1:0] nset, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				item_bus.valid <= 1'b0;
				repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6))
					@(posedge clk);
			end
		end
		item_bus.valid <= 1'b1;
		item_bus.mode <= mode;
		item_bus.row_state <= row;
		item_bus.symbol <= sym;
		item_bus.next_set <= nset;
		item_bus.last_symbol <= last;
		do @(posedge clk); while (item_bus.ready !== 1'b1);
		tracker.note_item(mode, row, sym, nset, last);
		burst_left--;
		if (mode == MODE_LOAD) begin
			loads++;
		end else begin
			symbols++;
			strings += last;
		end
	endtask

	// Load beats leave no verdict behind, so the block is given time to finish them too.
	task automatic drain_verdicts();
		item_bus.valid <= 1'b0;
		while (tracker.verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] want;
		want = '0;
		if (idx == REG_START_STATE) begin
			want[STATE_W-1:0] = value[STATE_W-1:0];
		end else begin
			want[MASK_W-1:0] = value[MASK_W-1:0];
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.write_reg(idx, value);
		settings++;
		if (prdata !== want) begin
			tracker.errors++;
			$display("%0t: register %s read back: expected %h, actual %h", $time, idx.name(),
				want, prdata);
		end
	endtask

	task automatic set_config(logic [STATE_W-1:0] start, logic [MASK_W-1:0] fmask);
		logic [PDATA_W-1:0] value;
		drain_verdicts();
		value = $urandom();
		value[STATE_W-1:0] = start;
		write_reg(REG_START_STATE, value);
		value = $urandom();
		value[MASK_W-1:0] = fmask;
		write_reg(REG_FINAL_MASK, value);
	endtask

	initial begin
		int k;
		int len;
		int pick;
		int count;
		bit chain;
		logic [MASK_W-1:0] nset;
		logic [SYM_W-1:0] sym;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_bus.valid <= 1'b0;
		item_bus.mode <= MODE_LOAD;
		item_bus.row_state <= '0;
		item_bus.symbol <= '0;
		item_bus.next_set <= '0;
		item_bus.last_symbol <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The table is empty after reset, so the first string dies at once.
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b0);
		send_item(MODE_SYMBOL, 4'd0, 5'd5, 16'hFFFF, 1'b1);
		set_config(4'd0, 16'hFFFF);
		send_item(MODE_LOAD, 4'd0, 5'd0, 16'hFFFF, 1'b0);
		send_item(MODE_LOAD, 4'd15, 5'd15, 16'h0001, 1'b0);
		send_item(MODE_LOAD, 4'd3, EPS_ROW, 16'h0010, 1'b0);
		send_item(MODE_LOAD, 4'd15, 5'd17, 16'hFFFF, 1'b0);
		send_item(MODE_LOAD, 4'd7, 5'd31, 16'hFFFF, 1'b0);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b0);
		send_item(MODE_SYMBOL, 4'd0, 5'd15, 16'h0000, 1'b0);
		send_item(MODE_SYMBOL, 4'd0, EPS_ROW, 16'h0000, 1'b0);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b1);
		send_item(MODE_SYMBOL, 4'd15, 5'd31, 16'hFFFF, 1'b1);
		send_item(MODE_LOAD, 4'd0, 5'd1, 16'h0000, 1'b1);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b1);
		set_config(4'd15, 16'h0000);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b1);
		send_item(MODE_SYMBOL, 4'd0, 5'd15, 16'h0000, 1'b0);
		set_config(4'd3, 16'h8000);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b1);
		send_item(MODE_SYMBOL, 4'd0, 5'd0, 16'h0000, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(4'd0, 16'hFFFF);
				1: set_config(4'd15, 16'h0000);
				default: set_config(STATE_W'($urandom_range(0, 15)),
					sparse_set(1) | sparse_set(1));
			endcase
			rx_mode = rx_pattern_t'(ph % 4);
			gaps_on = (ph % 3) != 2;
			k = (ph == PHASES - 1) ? SYMBOLS : $urandom_range(2, 4);
			chain = (ph % 3) == 1;
			for (int s = 0; s < STATES; s++) begin
				for (int c = 0; c <= k; c++) begin
					if (c < k) begin
						nset = sparse_set(6);
					end else if (chain) begin
						nset = (s < STATES - 1) ? MASK_W'(1) << (s + 1) : '0;
					end else begin
						nset = ($urandom_range(0, 3) == 0) ? sparse_set(8) : '0;
					end
					sym = (c < k) ? SYM_W'(c) : SYM_W'(EPS_ROW);
					send_item(MODE_LOAD, STATE_W'(s), sym, nset, 1'($urandom_range(0, 1)));
				end
			end
			count = 0;
			while (count < SYMBOLS_PER_PHASE) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					pick = $urandom_range(0, 99);
					if (pick < 4) begin
						send_item(MODE_LOAD, STATE_W'($urandom_range(0, 15)),
							SYM_W'($urandom_range(0, 31)), MASK_W'($urandom_range(0, 65535)),
							1'($urandom_range(0, 1)));
					end
					sym = (pick < 9) ? SYM_W'($urandom_range(k, 31)) :
						SYM_W'($urandom_range(0, k - 1));
					send_item(MODE_SYMBOL, STATE_W'($urandom_range(0, 15)), sym,
						MASK_W'($urandom_range(0, 65535)), i == len - 1);
					count++;
				end
			end
		end
		drain_verdicts();

		$display("tb_top: %0d row loads, %0d symbols in %0d strings, %0d register writes",
			loads, symbols, strings, settings);
		$display("tb_top: %0d verdicts checked, %0d accepting, %0d alive, %0d errors",
			tracker.checked, tracker.accepts, tracker.alives, tracker.errors);
		if (tracker.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
